// ===== src/flrwh_pkg.sv =====
// ----------------------------------------------------------------------------
// flrwh_pkg: shared types and constants of the four-lane rotating word hash
// Holds the hash constants, the micro-operation codes, the rotation table and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package flrwh_pkg;

  localparam int unsigned LenW = 32;

  localparam logic [63:0] KGold = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] KA    = 64'h85EBCA77C2B2AE3D;
  localparam logic [63:0] KB    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] KC    = 64'h94D049BB133111EB;
  localparam logic [63:0] KD    = 64'hA3C8B9D5E1F2A7B4;

  // Micro-operations: each one is a single 64-bit multiply and its write-back.
  localparam logic [3:0] OP_BASE   = 4'd0;
  localparam logic [3:0] OP_LANE0  = 4'd1;
  localparam logic [3:0] OP_LANE1  = 4'd2;
  localparam logic [3:0] OP_LANE2  = 4'd3;
  localparam logic [3:0] OP_LANE3  = 4'd4;
  localparam logic [3:0] OP_ABSORB = 4'd5;
  localparam logic [3:0] OP_FIN_A  = 4'd6;
  localparam logic [3:0] OP_FIN_C  = 4'd7;
  localparam logic [3:0] OP_MIX    = 4'd8;
  localparam logic [3:0] OP_R17    = 4'd9;
  localparam logic [3:0] OP_R23    = 4'd10;
  localparam logic [3:0] OP_R29    = 4'd11;
  localparam logic [3:0] OP_R37    = 4'd12;

  typedef struct packed {
    logic       load_start;
    logic       load_data;
    logic       issue;
    logic       write;
    logic       emit;
    logic [3:0] op;
  } flrwh_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic bytes_zero;
  } flrwh_stat_t;

  // Rotation per lane: even set for even block count, odd set otherwise.
  function automatic logic [5:0] rot_amount(input logic odd, input logic [1:0] lane);
    logic [5:0] r;
    unique case ({odd, lane})
      3'b000:  r = 6'd17;
      3'b001:  r = 6'd29;
      3'b010:  r = 6'd43;
      3'b011:  r = 6'd53;
      3'b100:  r = 6'd23;
      3'b101:  r = 6'd37;
      3'b110:  r = 6'd59;
      default: r = 6'd61;
    endcase
    return r;
  endfunction

endpackage

// ===== src/flrwh_mul.sv =====
// ----------------------------------------------------------------------------
// flrwh_mul: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 partial product per cycle, low by low and then the two cross
// terms; done pulses with the product held on p_o.
// ----------------------------------------------------------------------------
module flrwh_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0] a_q, b_q, p_q;
  logic [1:0]  cnt_q;
  logic        run_q, done_q;
  logic [31:0] sel_a, sel_b;
  logic [63:0] pp;

  always_comb begin
    unique case (cnt_q)
      2'd1:    begin sel_a = a_q[63:32]; sel_b = b_q[31:0];  end
      2'd2:    begin sel_a = a_q[31:0];  sel_b = b_q[63:32]; end
      default: begin sel_a = a_q[31:0];  sel_b = b_q[31:0];  end
    endcase
    pp = sel_a * sel_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= 2'd0;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd2) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (run_q) begin
      // cross terms only reach the upper half of the low 64 bits
      if (cnt_q == 2'd0) begin
        p_q <= pp;
      end else begin
        p_q <= p_q + {pp[31:0], 32'd0};
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ===== src/flrwh_dp.sv =====
// ----------------------------------------------------------------------------
// flrwh_dp: datapath of the four-lane rotating word hash
// Lanes, base, finalizer registers, byte and block counters, operand
// selection into the shared multiplier and result write-back.
// ----------------------------------------------------------------------------
module flrwh_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  flrwh_pkg::flrwh_cmd_t     cmd_i,
  input  logic [63:0]               data_i,
  input  logic [flrwh_pkg::LenW-1:0] length_i,
  output flrwh_pkg::flrwh_stat_t    stat_o,
  output logic [63:0]               digest_o
);

  logic [63:0] lane_q [4];
  logic [63:0] base_q, acc_q, c_q, word_q, digest_q;
  logic [flrwh_pkg::LenW-1:0] bytes_left_q;
  logic [1:0]  word_idx_q, fbc_q, lidx_q;

  logic [3:0]  take;
  logic [63:0] wmask, rot_w, opa, opk, prod;
  logic [127:0] dbl;
  logic        in_full, mul_done;
  logic [1:0]  lane_idx;
  logic [5:0]  rot;

  always_comb begin
    take = (bytes_left_q < flrwh_pkg::LenW'(8)) ? {1'b0, bytes_left_q[2:0]} : 4'd8;
    for (int b = 0; b < 8; b++) begin
      wmask[8*b +: 8] = ((take == 4'd8) || (3'(b) < bytes_left_q[2:0])) ?
                        word_q[8*b +: 8] : 8'd0;
    end
    in_full  = ({1'b0, bytes_left_q} + {28'd0, word_idx_q, 3'b000}) >= 33'd32;
    lane_idx = in_full ? word_idx_q : fbc_q;
    rot      = flrwh_pkg::rot_amount(fbc_q[0], lane_idx);
    dbl      = {wmask, wmask} << rot;
    rot_w    = dbl[127:64];
  end

  always_comb begin
    unique case (cmd_i.op)
      flrwh_pkg::OP_BASE:   begin opa = {32'd0, bytes_left_q};  opk = flrwh_pkg::KGold; end
      flrwh_pkg::OP_LANE0:  begin opa = base_q;                 opk = flrwh_pkg::KGold; end
      flrwh_pkg::OP_LANE1:  begin opa = base_q;                 opk = flrwh_pkg::KA;    end
      flrwh_pkg::OP_LANE2:  begin opa = base_q;                 opk = flrwh_pkg::KB;    end
      flrwh_pkg::OP_LANE3:  begin opa = base_q;                 opk = flrwh_pkg::KC;    end
      flrwh_pkg::OP_ABSORB: begin opa = lane_q[lane_idx] ^ rot_w; opk = flrwh_pkg::KGold; end
      flrwh_pkg::OP_FIN_A:  begin opa = lane_q[0] ^ lane_q[1];  opk = flrwh_pkg::KGold; end
      flrwh_pkg::OP_FIN_C:  begin opa = lane_q[2] ^ lane_q[3];  opk = flrwh_pkg::KGold; end
      flrwh_pkg::OP_MIX:    begin opa = acc_q ^ c_q;            opk = flrwh_pkg::KD;    end
      flrwh_pkg::OP_R17:    begin opa = acc_q ^ (acc_q >> 17);  opk = flrwh_pkg::KA;    end
      flrwh_pkg::OP_R23:    begin opa = acc_q ^ (acc_q >> 23);  opk = flrwh_pkg::KB;    end
      flrwh_pkg::OP_R29:    begin opa = acc_q ^ (acc_q >> 29);  opk = flrwh_pkg::KC;    end
      flrwh_pkg::OP_R37:    begin opa = acc_q ^ (acc_q >> 37);  opk = flrwh_pkg::KD;    end
      default:              begin opa = 64'd0;                  opk = 64'd0;            end
    endcase
  end

  flrwh_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.issue),
    .a_i     (opa),
    .b_i     (opk),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  // counters: advance when a word is issued to the multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      word_idx_q   <= 2'd0;
      fbc_q        <= 2'd0;
    end else if (cmd_i.load_start) begin
      bytes_left_q <= length_i;
      word_idx_q   <= 2'd0;
      fbc_q        <= 2'd0;
    end else if (cmd_i.issue && (cmd_i.op == flrwh_pkg::OP_ABSORB)) begin
      bytes_left_q <= bytes_left_q - {{(flrwh_pkg::LenW-4){1'b0}}, take};
      word_idx_q   <= word_idx_q + 2'd1;
      if (!in_full || (word_idx_q == 2'd3)) begin
        fbc_q <= fbc_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      base_q <= data_i;
    end
    if (cmd_i.load_data) begin
      word_q <= data_i;
    end
    if (cmd_i.issue) begin
      lidx_q <= lane_idx;
    end
    if (cmd_i.emit) begin
      digest_q <= acc_q ^ (acc_q >> 43);
    end
    if (cmd_i.write) begin
      unique case (cmd_i.op)
        flrwh_pkg::OP_BASE:   base_q      <= base_q ^ prod;
        flrwh_pkg::OP_LANE0:  lane_q[0]   <= prod;
        flrwh_pkg::OP_LANE1:  lane_q[1]   <= prod;
        flrwh_pkg::OP_LANE2:  lane_q[2]   <= prod;
        flrwh_pkg::OP_LANE3:  lane_q[3]   <= prod;
        flrwh_pkg::OP_ABSORB: lane_q[lidx_q] <= prod;
        flrwh_pkg::OP_FIN_C:  c_q         <= prod;
        default:              acc_q       <= prod;
      endcase
    end
  end

  assign stat_o.mul_done   = mul_done;
  assign stat_o.bytes_zero = (bytes_left_q == '0);
  assign digest_o          = digest_q;

endmodule

// ===== src/flrwh_ctrl.sv =====
// ----------------------------------------------------------------------------
// flrwh_ctrl: controller of the four-lane rotating word hash
// Accepts items, steps through the multiply sequence of seeding, absorbing
// and finalizing, and owns the output valid.
// ----------------------------------------------------------------------------
module flrwh_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  flrwh_pkg::flrwh_stat_t stat_i,
  output flrwh_pkg::flrwh_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPEN  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] op_q, op_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o = !((state_q == S_IDLE) || (state_q == S_OPEN));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    cmd_o.load_start = 1'b0;
    cmd_o.load_data  = 1'b0;
    cmd_o.issue      = 1'b0;
    cmd_o.write      = 1'b0;
    cmd_o.emit       = 1'b0;
    cmd_o.op         = op_q;

    unique case (state_q)
      S_IDLE, S_OPEN: begin
        if (accept) begin
          if (!action_i) begin
            cmd_o.load_start = 1'b1;
            op_d             = flrwh_pkg::OP_BASE;
            state_d          = S_ISSUE;
          end else if (state_q == S_OPEN) begin
            cmd_o.load_data = 1'b1;
            op_d            = flrwh_pkg::OP_ABSORB;
            state_d         = S_ISSUE;
          end
          // drop a data word while no message is open
        end
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.write = 1'b1;
          state_d     = S_ISSUE;
          unique case (op_q)
            flrwh_pkg::OP_BASE:  op_d = flrwh_pkg::OP_LANE0;
            flrwh_pkg::OP_LANE0: op_d = flrwh_pkg::OP_LANE1;
            flrwh_pkg::OP_LANE1: op_d = flrwh_pkg::OP_LANE2;
            flrwh_pkg::OP_LANE2: op_d = flrwh_pkg::OP_LANE3;
            flrwh_pkg::OP_LANE3, flrwh_pkg::OP_ABSORB: begin
              if (stat_i.bytes_zero) begin
                op_d = flrwh_pkg::OP_FIN_A;
              end else begin
                state_d = S_OPEN;
              end
            end
            flrwh_pkg::OP_FIN_A: op_d = flrwh_pkg::OP_FIN_C;
            flrwh_pkg::OP_FIN_C: op_d = flrwh_pkg::OP_MIX;
            flrwh_pkg::OP_MIX:   op_d = flrwh_pkg::OP_R17;
            flrwh_pkg::OP_R17:   op_d = flrwh_pkg::OP_R23;
            flrwh_pkg::OP_R23:   op_d = flrwh_pkg::OP_R29;
            flrwh_pkg::OP_R29:   op_d = flrwh_pkg::OP_R37;
            flrwh_pkg::OP_R37:   state_d = S_EMIT;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= flrwh_pkg::OP_BASE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/four_lane_rotating_word_hash_unit.sv =====
// ----------------------------------------------------------------------------
// four_lane_rotating_word_hash_unit: streaming four-lane 64-bit word hash
// Seeds four lanes from a start item, absorbs little-endian data words and
// emits a 64-bit digest once the message length is consumed.
// ----------------------------------------------------------------------------
// Every step runs through one shared 64x64 multiplier built from a single
// 32x32 unit that takes three passes per product; each multiply is issued,
// runs and is written back before the next is issued. A data word stalls
// the input until its multiply is written back. A start item runs the base
// multiply and four lane seeds before the next item is taken. The word that
// ends the message, or a start item of zero length, adds finalizing (seven
// multiplies and the digest write) before the digest appears. A finished
// digest waits in the output register while the next items are taken; the
// last step of the following message holds until it has been transferred.
// ----------------------------------------------------------------------------
module four_lane_rotating_word_hash_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [63:0]                data_i,
  input  logic [flrwh_pkg::LenW-1:0] length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [63:0]                digest_o
);

  flrwh_pkg::flrwh_cmd_t  cmd;
  flrwh_pkg::flrwh_stat_t stat;

  flrwh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  flrwh_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .data_i   (data_i),
    .length_i (length_i),
    .stat_o   (stat),
    .digest_o (digest_o)
  );

  // no transfer in while a multiply is being started
  a_issue_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> in_stall_o)
    else $error("multiply issued while input open");

  // never overwrite a digest that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("digest overwritten");

  // a result write-back and an input transfer never meet
  a_accept_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !cmd.write)
    else $error("write-back during input transfer");

  // the multiplier never finishes right after it was started
  a_mul_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |=> !stat.mul_done)
    else $error("multiplier done too early");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: four-lane rotating word hash unit
// Runs a short table of directed messages and then random messages, some of
// them abandoned, through the unit with random idling on both channels. A
// local hash predictor computes the expected digests, pinned table rows apart,
// and each digest transfer is compared with the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_WORD  = 1'b1
  } act_e;

  typedef struct packed {
    act_e        act;
    logic [63:0] data;
    logic [31:0] len;
    logic        pinned;
    logic [63:0] digest;
  } stim_row_t;

  localparam int DirRows = 18;
  localparam int RandItems = 500;
  localparam int IdlePct = 35;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       action_i = 1'b0;
  logic [63:0]                data_i = '0;
  logic [flrwh_pkg::LenW-1:0] length_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [63:0]                digest_o;

  // Hash predictor state
  logic [63:0] lane_acc [4];
  logic [29:0] words_seen;
  logic [31:0] remain;
  logic [26:0] blk_ctr;
  logic        in_msg;

  logic [63:0] pending_digests [$];
  int          bad_cnt = 0;
  int          taken = 0;
  logic        calm = 1'b0;
  logic [63:0] want;
  stim_row_t   dir_tab [DirRows];

  four_lane_rotating_word_hash_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rotl64(logic [63:0] x, logic [5:0] k);
    return (x << k) | (x >> (7'd64 - {1'b0, k}));
  endfunction

  function automatic logic [5:0] lane_rot(logic odd, logic [1:0] lane);
    logic [5:0] r;
    case (lane)
      2'd0:    r = odd ? 6'd23 : 6'd17;
      2'd1:    r = odd ? 6'd37 : 6'd29;
      2'd2:    r = odd ? 6'd59 : 6'd43;
      default: r = odd ? 6'd61 : 6'd53;
    endcase
    return r;
  endfunction

  task automatic fold_word(input logic [1:0] lane, input logic odd, input logic [63:0] w);
    lane_acc[lane] = (lane_acc[lane] ^ rotl64(w, lane_rot(odd, lane))) * flrwh_pkg::KGold;
  endtask

  function automatic logic [63:0] digest_of();
    logic [63:0] a;
    logic [63:0] c;
    a = (lane_acc[0] ^ lane_acc[1]) * flrwh_pkg::KGold;
    c = (lane_acc[2] ^ lane_acc[3]) * flrwh_pkg::KGold;
    a = (a ^ c) * flrwh_pkg::KD;
    a = (a ^ (a >> 17)) * flrwh_pkg::KA;
    a = (a ^ (a >> 23)) * flrwh_pkg::KB;
    a = (a ^ (a >> 29)) * flrwh_pkg::KC;
    a = (a ^ (a >> 37)) * flrwh_pkg::KD;
    a = a ^ (a >> 43);
    return a;
  endfunction

  task automatic step_hash(input act_e act, input logic [63:0] d, input logic [31:0] len,
                           output logic emits, output logic [63:0] dig);
    logic [63:0] base;
    logic [1:0]  k;
    logic [33:0] span;
    logic [3:0]  take;
    logic [63:0] w;
    emits = 1'b0;
    dig = '0;
    if (act == ACT_START) begin
      base = d ^ ({32'd0, len} * flrwh_pkg::KGold);
      lane_acc[0] = base * flrwh_pkg::KGold;
      lane_acc[1] = base * flrwh_pkg::KA;
      lane_acc[2] = base * flrwh_pkg::KB;
      lane_acc[3] = base * flrwh_pkg::KC;
      words_seen = '0;
      blk_ctr = '0;
      remain = len;
      in_msg = (len != 0);
      if (len == 0) begin
        emits = 1'b1;
        dig = digest_of();
      end
    end else if (in_msg) begin
      k = words_seen[1:0];
      span = {2'b00, remain} + {29'd0, k, 3'b000};
      take = (remain < 8) ? remain[3:0] : 4'd8;
      w = d;
      if (take < 8) w = d & ~({64{1'b1}} << (take * 8));
      if (span >= 34'd32) begin
        fold_word(k, blk_ctr[0], w);
        if (k == 2'd3) blk_ctr = blk_ctr + 1'b1;
      end else begin
        fold_word(blk_ctr[1:0], blk_ctr[0], w);
        blk_ctr = blk_ctr + 1'b1;
      end
      remain = remain - {28'd0, take};
      words_seen = words_seen + 1'b1;
      if (remain == 0) begin
        in_msg = 1'b0;
        emits = 1'b1;
        dig = digest_of();
      end
    end
  endtask

  // Drive one item, hold it until the transfer, then record its expectation.
  task automatic send(input act_e act, input logic [63:0] d, input logic [31:0] len,
                      input logic pinned, input logic [63:0] pin_dig);
    logic        emits;
    logic [63:0] dig;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    data_i     <= d;
    length_i   <= len;
    do @(posedge clk_i); while (in_stall_o);
    if (act == ACT_START || in_msg) taken++;
    step_hash(act, d, len, emits, dig);
    if (emits) pending_digests.push_back(pinned ? pin_dig : dig);
  endtask

  function automatic logic [63:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    if (pick == 1) return {64{1'b1}};
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digests.size() == 0) begin
        if (bad_cnt < 10) $display("unexpected digest %h", digest_o);
        bad_cnt++;
      end else begin
        want = pending_digests.pop_front();
        if (want !== digest_o) begin
          if (bad_cnt < 10) $display("digest mismatch: expected %h, got %h", want, digest_o);
          bad_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [31:0] len;
    int          nwords;
    int          cut;

    dir_tab = '{
      '{ACT_START, 64'h0000000000000000, 32'd0,          1'b1, 64'h0},
      '{ACT_WORD,  64'hFFFFFFFFFFFFFFFF, 32'd0,          1'b0, 64'h0},
      '{ACT_START, 64'hFFFFFFFFFFFFFFFF, 32'd1,          1'b0, 64'h0},
      '{ACT_WORD,  64'hFFFFFFFFFFFFFFFF, 32'd0,          1'b0, 64'h0},
      '{ACT_START, 64'h0123456789ABCDEF, 32'd40,         1'b0, 64'h0},
      '{ACT_WORD,  64'h1111111111111111, 32'd0,          1'b0, 64'h0},
      '{ACT_WORD,  64'h8000000000000001, 32'd0,          1'b0, 64'h0},
      '{ACT_WORD,  64'h0F0F0F0F0F0F0F0F, 32'd0,          1'b0, 64'h0},
      '{ACT_WORD,  64'hF0F0F0F0F0F0F0F0, 32'd0,          1'b0, 64'h0},
      '{ACT_WORD,  64'hFEDCBA9876543210, 32'd0,          1'b0, 64'h0},
      '{ACT_START, 64'hDEADBEEFCAFEF00D, 32'd20,         1'b0, 64'h0},
      '{ACT_WORD,  64'h0000000000000001, 32'd0,          1'b0, 64'h0},
      '{ACT_START, 64'h5555555555555555, 32'hFFFFFFFF,   1'b0, 64'h0},
      '{ACT_WORD,  64'hAAAAAAAAAAAAAAAA, 32'd0,          1'b0, 64'h0},
      '{ACT_START, 64'hFFFFFFFFFFFFFFFF, 32'd0,          1'b0, 64'h0},
      '{ACT_START, 64'h0000000000000001, 32'd15,         1'b0, 64'h0},
      '{ACT_WORD,  64'h7FFFFFFFFFFFFFFF, 32'd0,          1'b0, 64'h0},
      '{ACT_WORD,  64'hFFFFFFFFFFFFFFFF, 32'd0,          1'b0, 64'h0}
    };

    lane_acc   = '{default: '0};
    words_seen = '0;
    remain     = '0;
    blk_ctr    = '0;
    in_msg     = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++)
      send(dir_tab[i].act, dir_tab[i].data, dir_tab[i].len, dir_tab[i].pinned,
           dir_tab[i].digest);

    while (taken < DirRows + RandItems) begin
      calm = (taken >= 200 && taken < 300);
      pick = $urandom_range(99);
      if (pick < 6) begin
        send(ACT_WORD, rand_word(), $urandom(), 1'b0, '0);
      end else if (pick < 12) begin
        // full-range length, dropped after up to five words
        send(ACT_START, rand_word(), $urandom(), 1'b0, '0);
        nwords = $urandom_range(5);
        for (int j = 0; j < nwords; j++) send(ACT_WORD, rand_word(), $urandom(), 1'b0, '0);
      end else begin
        if ($urandom_range(9) == 0) len = $urandom_range(260, 73);
        else len = $urandom_range(72);
        nwords = (len + 7) / 8;
        cut = ($urandom_range(19) == 0) ? $urandom_range(nwords) : nwords;
        send(ACT_START, rand_word(), len, 1'b0, '0);
        for (int j = 0; j < cut; j++) send(ACT_WORD, rand_word(), $urandom(), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (bad_cnt == 0 && pending_digests.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== four_lane_rotating_word_hash_unit.f =====
src/flrwh_pkg.sv
src/flrwh_mul.sv
src/flrwh_dp.sv
src/flrwh_ctrl.sv
src/four_lane_rotating_word_hash_unit.sv
bench/testbench.sv
